// ===== sv/sffc_pkg.sv =====
package sffc_pkg;

  // Frame limits
  localparam int unsigned MAX_FRAMES      = 18;
  localparam int unsigned MAX_FRAME_CHARS = 255;

  // Character codes
  localparam logic [7:0] CH_START = 8'h40;  // '@'
  localparam logic [7:0] CH_END   = 8'h2A;  // '*'
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_X     = 8'h58;

  // One result transaction
  typedef struct packed {
    logic [7:0] byte_out;
    logic       in_frame;
    logic [7:0] char_position;
    logic [4:0] frame_number;
    logic       frame_end;
    logic       fcs_ok;
    logic       response_done;
    logic       response_ok;
    logic [7:0] end_code;
    logic       end_code_valid;
  } res_t;

  // Upper-case ASCII hex digit for a nibble
  function automatic logic [7:0] hex_up(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h37 + {4'h0, nib};
    end
    return ch;
  endfunction

  // Decode a hex character: bit 4 set when valid, low bits give the value
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'h00;
    if (ch inside {[8'h30:8'h39]}) begin
      r = {1'b1, ch[3:0]};
    end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== sv/sffc_rx_if.sv =====
interface sffc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sffc_res_if.sv =====
interface sffc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       in_frame;
  logic [7:0] char_position;
  logic [4:0] frame_number;
  logic       frame_end;
  logic       fcs_ok;
  logic       response_done;
  logic       response_ok;
  logic [7:0] end_code;
  logic       end_code_valid;

  modport source (
    output valid, output byte_out, output in_frame, output char_position,
    output frame_number, output frame_end, output fcs_ok, output response_done,
    output response_ok, output end_code, output end_code_valid, input ready
  );
  modport sink (
    input valid, input byte_out, input in_frame, input char_position,
    input frame_number, input frame_end, input fcs_ok, input response_done,
    input response_ok, input end_code, input end_code_valid, output ready
  );
endinterface

// ===== sv/sffc_parser.sv =====
module sffc_parser import sffc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  output res_t       res_o
);

  localparam logic [7:0] MaxPos   = 8'(MAX_FRAME_CHARS);
  localparam logic [4:0] MaxFrame = 5'(MAX_FRAMES - 1);

  logic       active_q, active_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] prev0_q, prev0_d, prev1_q, prev1_d;
  logic [7:0] pos_q, pos_d;
  logic [4:0] fc_q, fc_d;
  logic       all_ok_q, all_ok_d;
  logic [7:0] hdr0_q, hdr0_d, hdr1_q, hdr1_d;
  logic [7:0] code_q, code_d;
  logic       seen_q, seen_d;

  // State as seen by this character: '@' restarts everything
  logic       start, act;
  logic [7:0] xs, p0, p1, pos, h0, h1, cd;
  logic [4:0] fc;
  logic       aok, seen;
  logic       is_term, is_end, ok, code_en;
  logic [7:0] first;
  logic [4:0] hv, lv;

  always_comb begin
    start = (char_i == CH_START);
    act   = start | active_q;
    xs    = start ? 8'h00 : xor_q;
    p0    = start ? 8'h00 : prev0_q;
    p1    = start ? 8'h00 : prev1_q;
    pos   = start ? 8'h00 : pos_q;
    fc    = start ? 5'h00 : fc_q;
    aok   = start | all_ok_q;
    h0    = start ? 8'h00 : hdr0_q;
    h1    = start ? 8'h00 : hdr1_q;
    cd    = start ? 8'h00 : code_q;
    seen  = start ? 1'b0  : seen_q;
  end

  // Frame check and result fields
  always_comb begin
    is_term = (char_i == CH_CR) || (char_i == CH_END);
    is_end  = (char_i == CH_END);
    ok      = (pos >= 8'd2) && (p1 == hex_up(xs[7:4])) && (p0 == hex_up(xs[3:0]));
    code_en = seen && (h0 != CH_T) && (h0 != CH_X);

    res_o                = '0;
    res_o.byte_out       = char_i;
    if (act) begin
      res_o.in_frame      = 1'b1;
      res_o.char_position = pos;
      res_o.frame_number  = fc;
      if (is_term) begin
        res_o.frame_end = 1'b1;
        res_o.fcs_ok    = ok;
        if (is_end) begin
          res_o.response_done  = 1'b1;
          res_o.response_ok    = aok & ok;
          res_o.end_code       = code_en ? cd : 8'h00;
          res_o.end_code_valid = code_en;
        end
      end
    end
  end

  // Next state
  always_comb begin
    first    = (h0 == CH_Q) ? 8'd7 : 8'd5;
    hv       = hex_value(h1);
    lv       = hex_value(char_i);
    active_d = active_q;
    xor_d    = xor_q;
    prev0_d  = prev0_q;
    prev1_d  = prev1_q;
    pos_d    = pos_q;
    fc_d     = fc_q;
    all_ok_d = all_ok_q;
    hdr0_d   = hdr0_q;
    hdr1_d   = hdr1_q;
    code_d   = code_q;
    seen_d   = seen_q;
    if (act) begin
      active_d = 1'b1;
      xor_d    = xs;
      prev0_d  = p0;
      prev1_d  = p1;
      pos_d    = pos;
      fc_d     = fc;
      all_ok_d = aok;
      hdr0_d   = h0;
      hdr1_d   = h1;
      code_d   = cd;
      seen_d   = seen;
      if (is_term) begin
        if (is_end) begin
          active_d = 1'b0;
        end else begin
          all_ok_d = aok & ok;
          fc_d     = (fc < MaxFrame) ? fc + 5'd1 : fc;
          xor_d    = 8'h00;
          prev0_d  = 8'h00;
          prev1_d  = 8'h00;
          pos_d    = 8'h00;
        end
      end else begin
        // capture header command and end-code digits in the first frame
        if (fc == 5'd0) begin
          if (pos == 8'd3) begin
            hdr0_d = char_i;
          end else if (pos == first) begin
            hdr1_d = char_i;
          end else if (pos == first + 8'd1) begin
            seen_d = 1'b1;
            if (!hv[4]) begin
              code_d = 8'h00;
            end else if (!lv[4]) begin
              code_d = {4'h0, hv[3:0]};
            end else begin
              code_d = {hv[3:0], lv[3:0]};
            end
          end
        end
        if (pos >= 8'd2) begin
          xor_d = xs ^ p1;
        end
        prev1_d = p0;
        prev0_d = char_i;
        pos_d   = (pos < MaxPos) ? pos + 8'd1 : pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      xor_q    <= 8'h00;
      prev0_q  <= 8'h00;
      prev1_q  <= 8'h00;
      pos_q    <= 8'h00;
      fc_q     <= 5'h00;
      all_ok_q <= 1'b1;
      hdr0_q   <= 8'h00;
      hdr1_q   <= 8'h00;
      code_q   <= 8'h00;
      seen_q   <= 1'b0;
    end else if (step_i) begin
      active_q <= active_d;
      xor_q    <= xor_d;
      prev0_q  <= prev0_d;
      prev1_q  <= prev1_d;
      pos_q    <= pos_d;
      fc_q     <= fc_d;
      all_ok_q <= all_ok_d;
      hdr0_q   <= hdr0_d;
      hdr1_q   <= hdr1_d;
      code_q   <= code_d;
      seen_q   <= seen_d;
    end
  end

endmodule

// ===== sv/sffc_out_reg.sv =====
module sffc_out_reg import sffc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_valid_i,
  output logic load_ready_o,
  input  res_t res_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  // Take a new result when empty or when the current one leaves
  assign load_ready_o = !valid_q || ready_i;
  assign valid_o      = valid_q;
  assign res_o        = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== sv/serial_frame_fcs_checker.sv =====
// Channel  | Dir | Payload                                  | Transaction
// rx_i     | in  | rx_byte                                  | valid & ready
// res_o    | out | byte_out, in_frame, ..., end_code_valid  | valid & ready
//
// One character per cycle sustained while res_o is not stalled; a result passes through
// the input register and then the result register before it is offered on res_o.
// The frame state updates as a character moves from the input register into
// the result register, so the XOR and FCS compare sit in that single stage.
// Reset clears the stage valids and the frame state; no response is active.
// A stall on res_o holds the result register, and the input register once full;
// rx_i.ready drops only when both are full.
module serial_frame_fcs_checker import sffc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sffc_rx_if.sink    rx_i,
  sffc_res_if.source res_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       load_ready;
  logic       step;
  res_t       res_d, res_q;

  assign step       = in_valid_q && load_ready;
  assign rx_i.ready = !in_valid_q || load_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  sffc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_byte_q),
    .res_o  (res_d)
  );

  sffc_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid_q),
    .load_ready_o (load_ready),
    .res_i        (res_d),
    .valid_o      (res_o.valid),
    .ready_i      (res_o.ready),
    .res_o        (res_q)
  );

  assign res_o.byte_out       = res_q.byte_out;
  assign res_o.in_frame       = res_q.in_frame;
  assign res_o.char_position  = res_q.char_position;
  assign res_o.frame_number   = res_q.frame_number;
  assign res_o.frame_end      = res_q.frame_end;
  assign res_o.fcs_ok         = res_q.fcs_ok;
  assign res_o.response_done  = res_q.response_done;
  assign res_o.response_ok    = res_q.response_ok;
  assign res_o.end_code       = res_q.end_code;
  assign res_o.end_code_valid = res_q.end_code_valid;

endmodule

// ===== sv/sffc_checker.sv =====
module sffc_checker import sffc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [7:0] byte_out_i,
  input logic       in_frame_i,
  input logic [7:0] char_position_i,
  input logic [4:0] frame_number_i,
  input logic       frame_end_i,
  input logic       fcs_ok_i,
  input logic       response_done_i,
  input logic       response_ok_i,
  input logic       end_code_valid_i
);

  // Outside a response only the echoed byte is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !in_frame_i |-> char_position_i == 8'h00 && frame_number_i == 5'h00
      && !frame_end_i && !response_done_i)
    else $error("fields set outside a response");

  // Check and response flags only come with a closing character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (fcs_ok_i || response_done_i) |-> frame_end_i)
    else $error("check flag without frame end");

  // Response end only on '*', and its status flags only then
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (response_ok_i || end_code_valid_i || response_done_i)
      |-> response_done_i && byte_out_i == CH_END)
    else $error("response end on wrong character");

  // A start character always opens frame zero at position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && byte_out_i == CH_START
      |-> in_frame_i && char_position_i == 8'h00 && frame_number_i == 5'h00)
    else $error("start character not at frame origin");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(byte_out_i))
    else $error("stalled result changed");

endmodule

bind serial_frame_fcs_checker sffc_checker u_sffc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (res_o.valid),
  .ready_i          (res_o.ready),
  .byte_out_i       (res_o.byte_out),
  .in_frame_i       (res_o.in_frame),
  .char_position_i  (res_o.char_position),
  .frame_number_i   (res_o.frame_number),
  .frame_end_i      (res_o.frame_end),
  .fcs_ok_i         (res_o.fcs_ok),
  .response_done_i  (res_o.response_done),
  .response_ok_i    (res_o.response_ok),
  .end_code_valid_i (res_o.end_code_valid)
);

// ===== tb/serial_frame_fcs_checker_test.sv =====
module serial_frame_fcs_checker_test;
  import sffc_pkg::*;

  localparam int unsigned FRAMED_TARGET = 550;
  localparam int unsigned QUIET_TAIL    = 80;
  localparam int unsigned PARK_CYCLES   = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  typedef enum int {FCS_GOOD, FCS_BAD, FCS_LOWER, FCS_NONE} fcs_mode_e;
  typedef enum int {SHAPE_NORMAL, SHAPE_LONG, SHAPE_MANY} resp_shape_e;

  // Tracks the response parser and holds the results it expects, oldest first
  class fcs_frame_scoreboard;
    bit          active;
    logic [7:0]  xsum;
    logic [7:0]  last1;
    logic [7:0]  last2;
    logic [7:0]  pos;
    logic [4:0]  fnum;
    bit          all_ok;
    logic [7:0]  hdr_kind;
    logic [7:0]  code_hi;
    logic [7:0]  code;
    bit          code_seen;
    res_t        expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void begin_frame();
      xsum  = 8'h00;
      last1 = 8'h00;
      last2 = 8'h00;
      pos   = 8'h00;
    endfunction

    function void restart();
      active = 1'b0;
      begin_frame();
      fnum      = 5'd0;
      all_ok    = 1'b1;
      hdr_kind  = 8'h00;
      code_hi   = 8'h00;
      code      = 8'h00;
      code_seen = 1'b0;
    endfunction

    function logic [7:0] hex_char(logic [3:0] n);
      string digits;
      digits = "0123456789ABCDEF";
      return digits[n];
    endfunction

    // Value of a hex digit of either case, -1 for anything else
    function int digit_of(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
      if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
      if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
      return -1;
    endfunction

    // Note one accepted character; return 1 if it belongs to a response
    function bit note_char(logic [7:0] c);
      res_t r;
      bit   ok;
      bit   has_code;
      int   first;
      int   hi;
      int   lo;
      r = '0;
      r.byte_out = c;
      if (c == CH_START) begin
        restart();
        active = 1'b1;
      end
      if (active) begin
        r.in_frame      = 1'b1;
        r.char_position = pos;
        r.frame_number  = fnum;
        if (c == CH_CR || c == CH_END) begin
          ok = (pos >= 8'd2) && last2 == hex_char(xsum[7:4]) && last1 == hex_char(xsum[3:0]);
          r.frame_end = 1'b1;
          r.fcs_ok    = ok;
          if (c == CH_END) begin
            has_code = code_seen && hdr_kind != CH_T && hdr_kind != CH_X;
            r.response_done  = 1'b1;
            r.response_ok    = all_ok && ok;
            r.end_code       = has_code ? code : 8'h00;
            r.end_code_valid = has_code;
            active = 1'b0;
          end else begin
            if (!ok) all_ok = 1'b0;
            if (fnum < MAX_FRAMES - 1) fnum = fnum + 5'd1;
            begin_frame();
          end
        end else begin
          // capture the header kind and end-code digits of the first frame
          if (fnum == 5'd0) begin
            first = (hdr_kind == CH_Q) ? 7 : 5;
            if (pos == 8'd3) begin
              hdr_kind = c;
            end else if (pos == first) begin
              code_hi = c;
            end else if (pos == first + 1) begin
              hi = digit_of(code_hi);
              lo = digit_of(c);
              if (hi < 0) code = 8'h00;
              else if (lo < 0) code = hi[7:0];
              else code = hi[7:0] * 8'd16 + lo[7:0];
              code_seen = 1'b1;
            end
          end
          // the two newest characters stay out of the sum until the next one
          if (pos >= 8'd2) xsum ^= last2;
          last2 = last1;
          last1 = c;
          if (pos < MAX_FRAME_CHARS) pos = pos + 8'd1;
        end
      end
      expected_q.push_back(r);
      return r.in_frame;
    endfunction

    function void cmp(string name, logic [7:0] e, logic [7:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, actual %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_report(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected, byte_out %0h", got.byte_out);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("byte_out", e.byte_out, got.byte_out);
      cmp("in_frame", e.in_frame, got.in_frame);
      cmp("char_position", e.char_position, got.char_position);
      cmp("frame_number", e.frame_number, got.frame_number);
      cmp("frame_end", e.frame_end, got.frame_end);
      cmp("fcs_ok", e.fcs_ok, got.fcs_ok);
      cmp("response_done", e.response_done, got.response_done);
      cmp("response_ok", e.response_ok, got.response_ok);
      cmp("end_code", e.end_code, got.end_code);
      cmp("end_code_valid", e.end_code_valid, got.end_code_valid);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sffc_rx_if  rx_if ();
  sffc_res_if res_if ();

  serial_frame_fcs_checker dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  fcs_frame_scoreboard sb;
  logic [7:0]  tx_chars[$];
  logic [7:0]  frame_body[$];
  bit          quiet;
  bit          park_req;
  int unsigned framed_items;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = ~clk;
  end

  // Character with no framing meaning
  function automatic logic [7:0] safe_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_START || c == CH_END || c == CH_CR);
    return c;
  endfunction

  // End-code digit: mostly upper-case hex, some lower-case, some garbage
  function automatic logic [7:0] code_digit();
    string lower;
    int    sel;
    lower = "0123456789abcdef";
    sel = $urandom_range(0, 9);
    if (sel < 6) return sb.hex_char(4'($urandom_range(0, 15)));
    if (sel < 8) return lower[$urandom_range(0, 15)];
    return safe_char();
  endfunction

  function automatic fcs_mode_e pick_fcs_mode();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return FCS_BAD;
    if (sel == 2) return FCS_LOWER;
    if (sel == 3) return FCS_NONE;
    return FCS_GOOD;
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) frame_body.push_back(s[i]);
  endfunction

  // Append the pending frame body, its check characters and the terminator
  function automatic void close_frame(fcs_mode_e mode, logic [7:0] term);
    logic [7:0] sum;
    logic [7:0] hi;
    logic [7:0] lo;
    sum = 8'h00;
    foreach (frame_body[i]) sum ^= frame_body[i];
    hi = sb.hex_char(sum[7:4]);
    lo = sb.hex_char(sum[3:0]);
    case (mode)
      FCS_BAD: begin
        if ($urandom_range(0, 1) == 0) hi = sb.hex_char(sum[7:4] + 4'($urandom_range(1, 15)));
        else lo = sb.hex_char(sum[3:0] + 4'($urandom_range(1, 15)));
      end
      FCS_LOWER: begin
        if (hi >= "A") hi = hi | 8'h20;
        if (lo >= "A") lo = lo | 8'h20;
      end
      default: begin
      end
    endcase
    foreach (frame_body[i]) tx_chars.push_back(frame_body[i]);
    if (mode != FCS_NONE) begin
      tx_chars.push_back(hi);
      tx_chars.push_back(lo);
    end
    tx_chars.push_back(term);
    frame_body.delete();
  endfunction

  // Build one response, mostly well formed, with noise and breakage mixed in
  function automatic void build_response(resp_shape_e shape);
    int         nframes;
    int         sel;
    int         cut;
    logic [7:0] kind;
    sel = $urandom_range(0, 99);
    if (shape == SHAPE_MANY || sel < 4) nframes = $urandom_range(MAX_FRAMES, MAX_FRAMES + 3);
    else if (sel < 55) nframes = 1;
    else nframes = $urandom_range(2, 4);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) tx_chars.push_back(8'($urandom_range(0, 255)));
    end
    // header of the first frame
    frame_body.push_back(CH_START);
    frame_body.push_back(sb.hex_char(4'($urandom_range(0, 15))));
    frame_body.push_back(sb.hex_char(4'($urandom_range(0, 15))));
    sel = $urandom_range(0, 9);
    if (sel < 3) kind = CH_Q;
    else if (sel == 3) kind = CH_T;
    else if (sel == 4) kind = CH_X;
    else kind = safe_char();
    frame_body.push_back(kind);
    if (kind == CH_Q) repeat (3) frame_body.push_back(safe_char());
    else frame_body.push_back(safe_char());
    frame_body.push_back(code_digit());
    frame_body.push_back(code_digit());
    repeat ($urandom_range(0, 6)) frame_body.push_back(safe_char());
    // cut the header short at a random point, which can drop the end-code digits
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, frame_body.size() - 1);
      while (frame_body.size() > cut) void'(frame_body.pop_back());
    end
    for (int f = 0; f < nframes; f++) begin
      if (f > 0) repeat ($urandom_range(0, 8)) frame_body.push_back(safe_char());
      if (f == nframes - 1 && shape == SHAPE_LONG) begin
        repeat ($urandom_range(250, 300)) frame_body.push_back(safe_char());
      end
      close_frame(pick_fcs_mode(), (f == nframes - 1) ? CH_END : CH_CR);
    end
    // drop the tail now and then; the next start restarts the parser
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(1, tx_chars.size() - 1);
      while (tx_chars.size() > cut) void'(tx_chars.pop_back());
    end
    if ($urandom_range(0, 2) == 0) tx_chars.push_back(CH_CR);
  endfunction

  // Offer one character and hold it until the transaction completes
  task automatic send_char(input logic [7:0] c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= c;
    do @(posedge clk); while (!rx_if.ready);
    if (sb.note_char(c)) framed_items++;
  endtask

  task automatic flush_chars();
    while (tx_chars.size() > 0) send_char(tx_chars.pop_front());
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Result side: check each transaction, stall in bursts or when parked
  initial begin
    int unsigned hold;
    res_t        got;
    hold = 0;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.byte_out       = res_if.byte_out;
        got.in_frame       = res_if.in_frame;
        got.char_position  = res_if.char_position;
        got.frame_number   = res_if.frame_number;
        got.frame_end      = res_if.frame_end;
        got.fcs_ok         = res_if.fcs_ok;
        got.response_done  = res_if.response_done;
        got.response_ok    = res_if.response_ok;
        got.end_code       = res_if.end_code;
        got.end_code_valid = res_if.end_code_valid;
        sb.check_report(got);
      end
      if (park_req) begin
        park_req = 1'b0;
        hold = PARK_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        res_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 4) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Bound the run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("serial_frame_fcs_checker: mismatch");
    $finish;
  end

  // Stimulus
  initial begin
    int  iter;
    bit  parked;
    bit  paused;
    resp_shape_e shape;
    sb = new();
    quiet = 1'b0;
    park_req = 1'b0;
    framed_items = 0;
    parked = 1'b0;
    paused = 1'b0;
    iter = 0;
    rst_n <= 1'b0;
    rx_if.valid <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // characters outside any response are ignored
    tx_chars.push_back(8'h00);
    tx_chars.push_back(8'hFF);
    tx_chars.push_back(CH_CR);
    tx_chars.push_back(CH_END);
    // bare start and end: frame too short, no end code
    push_str("@");
    close_frame(FCS_NONE, CH_END);
    // good frame with a lower-case end-code digit
    push_str("@00RD1f");
    close_frame(FCS_GOOD, CH_END);
    // an unfinished response; the start that follows restarts it
    tx_chars.push_back(CH_START);
    tx_chars.push_back("0");
    // two frames, the first failing its check
    push_str("@A");
    close_frame(FCS_BAD, CH_CR);
    close_frame(FCS_GOOD, CH_END);
    flush_chars();

    while (framed_items < FRAMED_TARGET) begin
      if (!parked && framed_items >= 150) begin
        park_req = 1'b1;
        parked = 1'b1;
      end
      if (!paused && framed_items >= 300) begin
        rx_if.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        paused = 1'b1;
      end
      if (framed_items + QUIET_TAIL >= FRAMED_TARGET) quiet = 1'b1;
      if (iter == 1) shape = SHAPE_MANY;
      else if (iter == 3) shape = SHAPE_LONG;
      else shape = SHAPE_NORMAL;
      build_response(shape);
      flush_chars();
      iter++;
    end

    rx_if.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("serial_frame_fcs_checker: match");
    end else begin
      $display("serial_frame_fcs_checker: mismatch");
    end
    $finish;
  end

endmodule
